/* rtl/stepper_position_controller_defines.svh */
// Assertion macros for the stepper position controller RTL.
// Define NO_ASSERTIONS to compile every check away; no other dependency.
`ifndef STEPPER_POSITION_CONTROLLER_DEFINES_SVH
`define STEPPER_POSITION_CONTROLLER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define SPC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stepper controller: same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define SPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stepper controller: next-cycle check failed");
`else
`define SPC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SPC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/spc_pkg.sv */
// Shared widths, register codes, control word type and microcode table
// for the stepper position controller. No dependencies.
`default_nettype none

package spc_pkg;

   localparam int TIMER_BITS    = 24;
   localparam int POSITION_BITS = 16;

   localparam int GAIN_BITS   = 8;
   localparam int LIMIT_BITS  = 10;
   localparam int FACTOR_BITS = 27;

   localparam int ERR_BITS   = POSITION_BITS + 1;
   localparam int MAG_BITS   = ERR_BITS;
   localparam int MUL_A_BITS = (TIMER_BITS > GAIN_BITS) ? TIMER_BITS : GAIN_BITS;
   localparam int MUL_B_BITS = (MAG_BITS > LIMIT_BITS) ? MAG_BITS : LIMIT_BITS;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
   localparam int CMP_BITS   = (PROD_BITS > FACTOR_BITS) ? PROD_BITS : FACTOR_BITS;

   localparam int COIL_BITS  = 4;
   localparam int PHASE_BITS = 2;

   localparam int REQ_FIELD_BITS = 2 * POSITION_BITS + TIMER_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = ERR_BITS + COIL_BITS + PHASE_BITS + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_GAIN  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATE_LIMIT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICK_FACTOR = 2'd2;
   localparam int CSR_DATA_BITS = FACTOR_BITS;

   localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 8'd10;
   localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 10'd300;
   localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 27'd13000000;

   // Microprogram step addresses.
   localparam int PC_BITS = 3;
   localparam logic [PC_BITS-1:0] PC_IDLE     = 3'd0;
   localparam logic [PC_BITS-1:0] PC_MUL_RATE = 3'd1;
   localparam logic [PC_BITS-1:0] PC_CAP      = 3'd2;
   localparam logic [PC_BITS-1:0] PC_MUL_TIME = 3'd3;
   localparam logic [PC_BITS-1:0] PC_TEST     = 3'd4;
   localparam logic [PC_BITS-1:0] PC_STEP     = 3'd5;
   localparam logic [PC_BITS-1:0] PC_EMIT     = 3'd6;

   typedef struct packed {
      logic               wait_req;   // hold here until an input beat arrives
      logic               mul_en;     // load the product register
      logic               mul_time;   // 0: gain * magnitude, 1: elapsed * rate
      logic               cap_en;     // clamp product to the rate limit
      logic               test_jump;  // jump when no step is due
      logic               step_en;    // drive coils, move phase, record time
      logic               emit;       // hand the result to the output register
      logic [PC_BITS-1:0] jump_to;
   } spc_uword_type;

   typedef struct packed {
      logic start;
      logic no_step;
      logic out_free;
   } spc_status_type;

   function automatic spc_uword_type spc_ucode(input logic [PC_BITS-1:0] pc);
      spc_uword_type uw;
      uw = '0;
      case (pc)
         PC_IDLE: begin
            uw.wait_req = 1'b1;
            uw.jump_to  = PC_MUL_RATE;
         end
         PC_MUL_RATE: begin
            uw.mul_en = 1'b1;
         end
         PC_CAP: begin
            uw.cap_en = 1'b1;
         end
         PC_MUL_TIME: begin
            uw.mul_en   = 1'b1;
            uw.mul_time = 1'b1;
         end
         PC_TEST: begin
            uw.test_jump = 1'b1;
            uw.jump_to   = PC_EMIT;
         end
         PC_STEP: begin
            uw.step_en = 1'b1;
         end
         PC_EMIT: begin
            uw.emit    = 1'b1;
            uw.jump_to = PC_IDLE;
         end
         default: begin
            uw.jump_to = PC_IDLE;
         end
      endcase
      return uw;
   endfunction

   function automatic logic [COIL_BITS-1:0] spc_coil_pattern(
      input logic [PHASE_BITS-1:0] ph);
      logic [COIL_BITS-1:0] pat;
      case (ph)
         2'd0:    pat = 4'b1010;
         2'd1:    pat = 4'b0110;
         2'd2:    pat = 4'b0101;
         default: pat = 4'b1001;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

/* rtl/stepper_position_controller.sv */
// Top level of the stepper position controller: stream ports, configuration
// registers, output register. Depends on spc_pkg, spc_sequencer, spc_datapath and the assertion macro header.
`default_nettype none
`include "stepper_position_controller_defines.svh"

// Full-step stepper drive with proportional speed. Each request beat carries
// encoder position, target position and a down-counting 24-bit timer
// reading; each beat yields exactly one response beat with the position
// error (target minus encoder), the coil levels now held, the phase the next
// step will drive and a flag that is set when this beat stepped the motor.
// The step rate is speed_gain * |error| capped at rate_limit; a step is taken
// when the ticks since the last step exceed floor(tick_factor / rate), tested
// exactly as ticks * rate > tick_factor. A short microprogram runs one
// item at a time through a single shared multiplier, so a request beat is
// taken only once the last one has passed its emit step, which waits while
// the output register is still full. The response register lets the next
// request beat be taken while a result waits on rsp_tready. Configuration
// writes are taken every cycle (csr_ready stays high) and must be issued only
// while the block is idle; an index outside the register list is ignored.
module stepper_position_controller (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request stream.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // tdata, from bit 0 up: encoder_position, target_position, timer_value
   input  wire logic [spc_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // Response stream.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // tdata, from bit 0 up: position_error, coil_drive, phase_index, stepped
   output logic [spc_pkg::RSP_DATA_BITS-1:0]         rsp_tdata,
   // Configuration write channel.
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [spc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [spc_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int P = spc_pkg::POSITION_BITS;
   localparam int T = spc_pkg::TIMER_BITS;

   spc_pkg::spc_uword_type  uword;
   spc_pkg::spc_status_type status;

   logic [spc_pkg::GAIN_BITS-1:0]   gain_ff;
   logic [spc_pkg::LIMIT_BITS-1:0]  limit_ff;
   logic [spc_pkg::FACTOR_BITS-1:0] factor_ff;

   logic                                rsp_valid_ff;
   logic [spc_pkg::RSP_DATA_BITS-1:0]   rsp_data_ff;
   logic [spc_pkg::RSP_DATA_BITS-1:0]   rsp_data_in;

   logic signed [spc_pkg::ERR_BITS-1:0] position_error;
   logic [spc_pkg::COIL_BITS-1:0]       coil_drive;
   logic [spc_pkg::PHASE_BITS-1:0]      phase_index;
   logic                                stepped;
   logic                                no_step;

   logic req_accept;
   logic rsp_load;

   // Take a request beat only while the microprogram waits at its idle step.
   assign req_tready = uword.wait_req;
   assign req_accept = req_tvalid && req_tready;

   assign status.start    = req_tvalid;
   assign status.no_step  = no_step;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // Load the output register at the emit step once it is free.
   assign rsp_load = uword.emit && status.out_free;

   spc_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .uword  (uword)
   );

   spc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .uword            (uword),
      .load             (req_accept),
      .encoder_position (req_tdata[P-1:0]),
      .target_position  (req_tdata[2*P-1:P]),
      .timer_value      (req_tdata[2*P+T-1:2*P]),
      .speed_gain       (gain_ff),
      .rate_limit       (limit_ff),
      .tick_factor      (factor_ff),
      .no_step          (no_step),
      .position_error   (position_error),
      .coil_drive       (coil_drive),
      .phase_index      (phase_index),
      .stepped          (stepped)
   );

   // Configuration registers: accept every write beat, drop unknown indexes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= spc_pkg::GAIN_RESET;
         limit_ff  <= spc_pkg::LIMIT_RESET;
         factor_ff <= spc_pkg::FACTOR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            spc_pkg::CSR_SPEED_GAIN:  gain_ff   <= csr_data[spc_pkg::GAIN_BITS-1:0];
            spc_pkg::CSR_RATE_LIMIT:  limit_ff  <= csr_data[spc_pkg::LIMIT_BITS-1:0];
            spc_pkg::CSR_TICK_FACTOR: factor_ff <= csr_data[spc_pkg::FACTOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Pack the result fields, error in the lowest bits.
   assign rsp_data_in = spc_pkg::RSP_DATA_BITS'({stepped, phase_index, coil_drive,
                                                 position_error});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A step is taken only right after a test that found it due.
   `SPC_ASSERT_IMP(a_step_after_test, clock, reset, uword.step_en, $past(uword.test_jump) && !$past(no_step))
   // The block is busy for at least the cycle after it takes a request beat.
   `SPC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, !req_tready)
   // A pending result is never overwritten.
   `SPC_ASSERT_IMP(a_no_overwrite, clock, reset, rsp_load, !rsp_valid_ff || rsp_tready)
   // A beat that stepped always drives a live coil pattern.
   `SPC_ASSERT_IMP(a_step_drives_coils, clock, reset, rsp_load && stepped, coil_drive != '0)

endmodule

`default_nettype wire

/* rtl/spc_sequencer.sv */
// Microprogram sequencer: step counter, control word lookup and jumps.
// Depends on spc_pkg for the control word type and the microcode table.
`default_nettype none

module spc_sequencer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire spc_pkg::spc_status_type status,
   output spc_pkg::spc_uword_type      uword
);

   logic [spc_pkg::PC_BITS-1:0] pc_ff;
   logic [spc_pkg::PC_BITS-1:0] pc_in;
   logic [spc_pkg::PC_BITS-1:0] pc_inc;

   always_comb begin
      uword  = spc_pkg::spc_ucode(pc_ff);
      pc_inc = spc_pkg::PC_BITS'(pc_ff + 1'b1);
      if (uword.wait_req) begin
         pc_in = status.start ? uword.jump_to : pc_ff;
      end else if (uword.test_jump) begin
         pc_in = status.no_step ? uword.jump_to : pc_inc;
      end else if (uword.emit) begin
         pc_in = status.out_free ? uword.jump_to : pc_ff;
      end else begin
         pc_in = pc_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= spc_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/spc_datapath.sv */
// Datapath: error, elapsed ticks, shared multiplier, rate cap, step test
// and the phase/coil/time state. Depends on spc_pkg.
`default_nettype none

module spc_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire spc_pkg::spc_uword_type                 uword,
   input  wire logic                                   load,
   input  wire logic signed [spc_pkg::POSITION_BITS-1:0] encoder_position,
   input  wire logic signed [spc_pkg::POSITION_BITS-1:0] target_position,
   input  wire logic [spc_pkg::TIMER_BITS-1:0]         timer_value,
   input  wire logic [spc_pkg::GAIN_BITS-1:0]          speed_gain,
   input  wire logic [spc_pkg::LIMIT_BITS-1:0]         rate_limit,
   input  wire logic [spc_pkg::FACTOR_BITS-1:0]        tick_factor,
   output logic                                        no_step,
   output logic signed [spc_pkg::ERR_BITS-1:0]         position_error,
   output logic [spc_pkg::COIL_BITS-1:0]               coil_drive,
   output logic [spc_pkg::PHASE_BITS-1:0]              phase_index,
   output logic                                        stepped
);

   logic signed [spc_pkg::ERR_BITS-1:0]   err_ff, err_in;
   logic [spc_pkg::MAG_BITS-1:0]          mag_ff, mag_in;
   logic [spc_pkg::TIMER_BITS-1:0]        elapsed_ff, elapsed_in;
   logic [spc_pkg::TIMER_BITS-1:0]        now_ff;
   logic [spc_pkg::TIMER_BITS-1:0]        diff;
   logic [spc_pkg::PROD_BITS-1:0]         prod_ff, prod_in;
   logic [spc_pkg::LIMIT_BITS-1:0]        rate_ff;
   logic [spc_pkg::MUL_A_BITS-1:0]        op_a;
   logic [spc_pkg::MUL_B_BITS-1:0]        op_b;
   logic [spc_pkg::CMP_BITS-1:0]          prod_cmp;
   logic [spc_pkg::PHASE_BITS-1:0]        phase_ff;
   logic [spc_pkg::TIMER_BITS-1:0]        last_ff;
   logic [spc_pkg::COIL_BITS-1:0]         coil_ff;
   logic                                  stepped_ff;

   always_comb begin
      err_in = spc_pkg::ERR_BITS'(target_position) - spc_pkg::ERR_BITS'(encoder_position);
      mag_in = err_in[spc_pkg::ERR_BITS-1] ? spc_pkg::MAG_BITS'(-err_in)
                                           : spc_pkg::MAG_BITS'(err_in);
      // Down-counting timer: a reading above the last step means one wrap.
      diff = last_ff - timer_value;
      elapsed_in = (timer_value <= last_ff) ? diff
                                            : spc_pkg::TIMER_BITS'(diff - 1'b1);
      if (uword.mul_time) begin
         op_a = spc_pkg::MUL_A_BITS'(elapsed_ff);
         op_b = spc_pkg::MUL_B_BITS'(rate_ff);
      end else begin
         op_a = spc_pkg::MUL_A_BITS'(speed_gain);
         op_b = spc_pkg::MUL_B_BITS'(mag_ff);
      end
      prod_in  = spc_pkg::PROD_BITS'(op_a) * spc_pkg::PROD_BITS'(op_b);
      prod_cmp = spc_pkg::CMP_BITS'(prod_ff);
      // elapsed > floor(factor / rate) is the same as elapsed * rate > factor.
      no_step  = !(prod_cmp > spc_pkg::CMP_BITS'(tick_factor));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_ff     <= err_in;
         mag_ff     <= mag_in;
         elapsed_ff <= elapsed_in;
         now_ff     <= timer_value;
      end
      if (uword.mul_en) begin
         prod_ff <= prod_in;
      end
      if (uword.cap_en) begin
         rate_ff <= (prod_cmp > spc_pkg::CMP_BITS'(rate_limit))
                    ? rate_limit : prod_ff[spc_pkg::LIMIT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         last_ff    <= '0;
         coil_ff    <= '0;
         stepped_ff <= 1'b0;
      end else begin
         if (load) begin
            stepped_ff <= 1'b0;
         end
         if (uword.step_en) begin
            coil_ff    <= spc_pkg::spc_coil_pattern(phase_ff);
            phase_ff   <= err_ff[spc_pkg::ERR_BITS-1]
                          ? spc_pkg::PHASE_BITS'(phase_ff - 1'b1)
                          : spc_pkg::PHASE_BITS'(phase_ff + 1'b1);
            last_ff    <= now_ff;
            stepped_ff <= 1'b1;
         end
      end
   end

   assign position_error = err_ff;
   assign coil_drive     = coil_ff;
   assign phase_index    = phase_ff;
   assign stepped        = stepped_ff;

endmodule

`default_nettype wire
